@@ rtl/assert_macros.svh @@
// Assertion macros shared by the nearest point search RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/nps_pkg.sv @@
// Types and constants of the nearest point search unit.
// Used by every module of the block but nps_ram; depends on nothing.
package nps_pkg;

  localparam int COORD_BITS = 24;
  localparam int IDX_BITS   = 10;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } nps_in_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] nearest_index;
    logic                found;
    logic                overflow;
  } nps_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } nps_point_t;

  // Word handed from cell to cell along the distance chain.
  typedef struct packed {
    logic             valid;
    logic             last;
    nps_point_t       pt;
    logic [SUM_W-1:0] sum;
  } nps_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } nps_state_t;

endpackage

@@ rtl/nps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module nps_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with a registered output.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/nps_cell.sv @@
// One cell of the distance chain: squares the x offset to its query coordinate,
// adds it to the running sum and hands the word on with the axes rotated.
// Depends on nps_pkg.
module nps_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_load,
  input  logic signed [nps_pkg::COORD_BITS-1:0] q_value,
  input  nps_pkg::nps_word_t                    word_in,
  output nps_pkg::nps_word_t                    word_out
);

  localparam int CB = nps_pkg::COORD_BITS;

  logic signed [CB-1:0]      q;
  logic signed [CB:0]        diff;
  logic signed [CB:0]        mag_full;
  logic [CB-1:0]             mag1;
  logic [nps_pkg::SQ_W-1:0]  sq2;
  nps_pkg::nps_word_t        w1;
  nps_pkg::nps_word_t        w2;
  nps_pkg::nps_word_t        w3;
  logic                      v1;
  logic                      v2;
  logic                      v3;

  // Form the magnitude of the offset on this cell's axis.
  always_comb begin
    diff     = (CB + 1)'(word_in.pt.x) - (CB + 1)'(q);
    mag_full = diff[CB] ? -diff : diff;
  end

  // Hold the query coordinate for the whole scan.
  always_ff @(posedge clk) begin
    if (q_load) begin
      q <= q_value;
    end
  end

  // Advance valid bits through the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= word_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1 takes the offset and rotates the axes, stage 2 squares,
  // stage 3 accumulates.
  always_ff @(posedge clk) begin
    mag1 <= mag_full[CB-1:0];
    w1   <= '{valid: word_in.valid, last: word_in.last,
              pt: '{x: word_in.pt.y, y: word_in.pt.z, z: word_in.pt.x},
              sum: word_in.sum};
    sq2  <= nps_pkg::SQ_W'(mag1) * nps_pkg::SQ_W'(mag1);
    w2   <= w1;
    w3   <= '{valid: w2.valid, last: w2.last, pt: w2.pt,
              sum: w2.sum + nps_pkg::SUM_W'(sq2)};
  end

  assign word_out = '{valid: v3, last: w3.last, pt: w3.pt, sum: w3.sum};

endmodule

@@ rtl/nps_min.sv @@
// Running minimum at the end of the distance chain: counts arriving words,
// keeps the earliest index of the smallest sum, pulses done on the last word.
// Depends on nps_pkg.
module nps_min #(
  parameter int AW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  nps_pkg::nps_word_t word_in,
  output logic               done,
  output logic [AW-1:0]      best_idx
);

  logic [AW-1:0]             idx;
  logic [nps_pkg::SUM_W-1:0] best_sum;
  logic                      take;

  // Strict less-than keeps the earlier index on ties.
  assign take = (idx == '0) || (word_in.sum < best_sum);

  // Advance the index counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= word_in.valid && word_in.last;
      if (word_in.valid) begin
        idx <= word_in.last ? '0 : idx + AW'(1);
      end
    end
  end

  // Hold the best candidate so far.
  always_ff @(posedge clk) begin
    if (word_in.valid && take) begin
      best_sum <= word_in.sum;
      best_idx <= idx;
    end
  end

endmodule

@@ rtl/nearest_point_search_unit.sv @@
// Nearest point search unit: point table in RAM, a chain of three distance
// cells and a running minimum. Depends on nps_pkg, nps_ram, nps_cell, nps_min.
//
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   Load writes the point at the next free index and returns that index, or
//   overflow when the table already holds MAX_POINTS points. Clear empties the
//   table and returns nothing; operation code 3 is ignored.
//   Query returns the load-order index of the stored point with the smallest
//   squared Euclidean distance, earliest index on ties, with found set; an
//   empty table answers index 0, found clear.
//   Each result word shows on result for exactly one cycle with result_strobe
//   high; the receiver cannot stall, so nothing waits on it.
// Sequencing:
//   Load, clear and an empty query keep busy low, so these may come every
//   cycle; a load or empty query result is registered and shows in the cycle
//   after acceptance. A query keeps busy high through one RAM read per point,
//   nine cell stages, the minimum stage and the result register.
// Reset: clears the point count and the control state; the RAM is not cleared,
//   entries are only read below the count.
module nearest_point_search_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nps_pkg::nps_in_t  command,
  output nps_pkg::nps_out_t result,
  output logic              result_strobe
);

`include "assert_macros.svh"

  localparam int AW = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = AW > nps_pkg::IDX_BITS ? AW : nps_pkg::IDX_BITS;
  localparam int PW = $bits(nps_pkg::nps_point_t);

  nps_pkg::nps_state_t state;
  nps_pkg::nps_state_t state_next;
  logic [CW-1:0]       count;
  logic [AW-1:0]       scan_addr;
  logic                accept;
  logic                full;
  logic                full_load;
  logic                wr_en;
  logic                rd_en;
  logic                last_issue;
  logic                rd_valid;
  logic                rd_last;
  logic [PW-1:0]       rd_data;
  nps_pkg::nps_word_t  w0;
  nps_pkg::nps_word_t  w1;
  nps_pkg::nps_word_t  w2;
  nps_pkg::nps_word_t  w3;
  logic                q_load;
  logic                min_done;
  logic [AW-1:0]       min_idx;

  function automatic logic [nps_pkg::IDX_BITS-1:0] to_index(logic [AW-1:0] v);
    logic [IW-1:0] w;
    w = IW'(v);
    return w[nps_pkg::IDX_BITS-1:0];
  endfunction

  assign accept     = start && !busy;
  assign full       = (count == CW'(MAX_POINTS));
  assign last_issue = (CW'(scan_addr) == count - CW'(1));
  assign wr_en      = accept && (command.operation == nps_pkg::OP_LOAD) && !full;
  assign full_load  = accept && (command.operation == nps_pkg::OP_LOAD) && full;
  assign q_load     = accept && (command.operation == nps_pkg::OP_QUERY);

  // Hold the sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, busy and read enable.
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    rd_en      = 1'b0;
    case (state)
      nps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (q_load && (count != '0)) begin
          state_next = nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (last_issue) begin
          state_next = nps_pkg::ST_DRAIN;
        end
      end
      nps_pkg::ST_DRAIN: begin
        if (min_done) begin
          state_next = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  // Count points, step the scan address and drive the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      result_strobe <= 1'b0;
      rd_valid      <= 1'b0;
      rd_last       <= 1'b0;
    end else begin
      result_strobe <= (accept && (command.operation == nps_pkg::OP_LOAD)) ||
                       (q_load && (count == '0)) ||
                       ((state == nps_pkg::ST_DRAIN) && min_done);
      rd_valid      <= rd_en;
      rd_last       <= rd_en && last_issue;
      if (accept) begin
        case (command.operation)
          nps_pkg::OP_LOAD: begin
            if (full) begin
              result <= '{nearest_index: '0, found: 1'b0, overflow: 1'b1};
            end else begin
              result <= '{nearest_index: to_index(count[AW-1:0]), found: 1'b0,
                          overflow: 1'b0};
              count  <= count + CW'(1);
            end
          end
          nps_pkg::OP_QUERY: begin
            scan_addr <= '0;
            if (count == '0) begin
              result <= '{nearest_index: '0, found: 1'b0, overflow: 1'b0};
            end
          end
          nps_pkg::OP_CLEAR: begin
            count <= '0;
          end
          default: begin
          end
        endcase
      end
      if (rd_en) begin
        scan_addr <= scan_addr + AW'(1);
      end
      if ((state == nps_pkg::ST_DRAIN) && min_done) begin
        result <= '{nearest_index: to_index(min_idx), found: 1'b1, overflow: 1'b0};
      end
    end
  end

  nps_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (PW'({command.coord_x, command.coord_y, command.coord_z})),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // Feed the chain with a fresh sum for each point read.
  assign w0 = '{valid: rd_valid, last: rd_last, pt: nps_pkg::nps_point_t'(rd_data),
                sum: '0};

  nps_cell u_cell_x (
    .clk (clk), .rst (rst), .q_load (q_load), .q_value (command.coord_x),
    .word_in (w0), .word_out (w1)
  );

  nps_cell u_cell_y (
    .clk (clk), .rst (rst), .q_load (q_load), .q_value (command.coord_y),
    .word_in (w1), .word_out (w2)
  );

  nps_cell u_cell_z (
    .clk (clk), .rst (rst), .q_load (q_load), .q_value (command.coord_z),
    .word_in (w2), .word_out (w3)
  );

  nps_min #(
    .AW (AW)
  ) u_min (
    .clk      (clk),
    .rst      (rst),
    .word_in  (w3),
    .done     (min_done),
    .best_idx (min_idx)
  );

  `ASSERT_IMPLY(a_no_result_in_scan, clk, rst, state == nps_pkg::ST_SCAN, !result_strobe)
  `ASSERT_IMPLY(a_done_only_in_drain, clk, rst, min_done, state == nps_pkg::ST_DRAIN)
  `ASSERT_IMPLY(a_last_read_drains, clk, rst, rd_valid && rd_last, state == nps_pkg::ST_DRAIN)
  `ASSERT_NEXT(a_full_load_flags, clk, rst, full_load, result_strobe && result.overflow)

endmodule
